// ----- sv/lpd_pkg.sv -----
package lpd_pkg;

	localparam int BUFFER_DEPTH_DEFAULT = 64;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_TYPE    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_TERMINATOR_BYTE = 1'b1;

	localparam logic [7:0] FORWARD_TYPE_RESET    = 8'h01;
	localparam logic [7:0] TERMINATOR_BYTE_RESET = 8'h0a;
	localparam logic [7:0] FRAME_LENGTH_RESET    = 8'h01;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_SEND = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		L_IDLE = 2'b01,
		L_LOAD = 2'b10
	} load_t;

endpackage

// ----- sv/lpd_ram.sv -----
module lpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sv/length_prefixed_packet_deframer.sv -----
// Channel   | Handshake           | Payload
// rx        | rx_valid / rx_ready | rx_byte[7:0]
// tx        | tx_valid / tx_ready | tx_byte[7:0], last_byte
// cfg       | cfg_we (no wait)    | cfg_index, cfg_data[7:0]
//
// rx_ready is high whenever no frame is being forwarded.
// A forwarding frame of n stored bytes sends bytes 1 to n-1 (not the type byte); each
// byte is read from the RAM, loaded into the output register, then transferred on tx.
// Reset clears fill count and sync flag and sets frame length and the config registers
// to their reset values; the store, type and output registers are not reset.
// A stall on tx holds the output register and the sequencer; rx stays closed meanwhile.
module length_prefixed_packet_deframer #(
	parameter int BUFFER_DEPTH = lpd_pkg::BUFFER_DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rx_valid,
	output logic                               rx_ready,
	input  logic [7:0]                         rx_byte,
	output logic                               tx_valid,
	input  logic                               tx_ready,
	output logic [7:0]                         tx_byte,
	output logic                               last_byte,
	input  logic                               cfg_we,
	input  logic [lpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [lpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import lpd_pkg::*;

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int FW = $clog2(BUFFER_DEPTH + 1);
	localparam int CW = (FW > 8) ? FW : 8;

	state_t        state_q;
	load_t         load_q;
	logic [7:0]    forward_type_q;
	logic [7:0]    terminator_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_n;
	logic [7:0]    len_q;
	logic [7:0]    len_n;
	logic [7:0]    type_q;
	logic [7:0]    type_n;
	logic          awaiting_q;
	logic          awaiting_n;
	logic [AW-1:0] idx_q;
	logic [7:0]    tx_byte_q;
	logic          last_q;

	logic          rx_acc;
	logic          tx_acc;
	logic          store_ok;
	logic          is_term;
	logic          match;
	logic          emit;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic          idx_last;

	assign rx_ready = (state_q == S_IDLE);
	assign tx_valid = (state_q == S_SEND) && (load_q == L_IDLE);
	assign rx_acc   = rx_valid && rx_ready;
	assign tx_acc   = tx_valid && tx_ready;
	assign tx_byte  = tx_byte_q;
	assign last_byte = last_q;

	always_comb begin
		store_ok = !awaiting_q && (fill_q < FW'(BUFFER_DEPTH)) && (CW'(fill_q) < CW'(len_q));
		if (awaiting_q) begin
			fill_n = '0;
			len_n  = rx_byte;
		end else begin
			fill_n = store_ok ? fill_q + FW'(1) : fill_q;
			len_n  = len_q;
		end
		type_n     = (store_ok && (fill_q == '0)) ? rx_byte : type_q;
		is_term    = (rx_byte == terminator_q);
		match      = (CW'(fill_n) == CW'(len_n));
		emit       = is_term && match && (fill_n >= FW'(2)) && (type_n == forward_type_q);
		awaiting_n = is_term && (match || (fill_n >= FW'(BUFFER_DEPTH)));
	end

	assign idx_last = ((FW'(idx_q) + FW'(1)) == fill_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		case (state_q)
			S_READ: begin
				rd_en = 1'b1;
			end
			S_SEND: begin
				if (tx_acc && !last_q) begin
					rd_en   = 1'b1;
					rd_addr = idx_q + AW'(1);
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	lpd_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (rx_acc && store_ok),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (rx_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			load_q         <= L_IDLE;
			forward_type_q <= FORWARD_TYPE_RESET;
			terminator_q   <= TERMINATOR_BYTE_RESET;
			fill_q         <= '0;
			len_q          <= FRAME_LENGTH_RESET;
			awaiting_q     <= 1'b0;
			idx_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FORWARD_TYPE:    forward_type_q <= cfg_data;
					REG_TERMINATOR_BYTE: terminator_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (rx_acc) begin
						fill_q     <= fill_n;
						len_q      <= len_n;
						awaiting_q <= awaiting_n;
						if (emit) begin
							idx_q   <= AW'(1);
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					load_q  <= L_LOAD;
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (load_q == L_LOAD) begin
						load_q <= L_IDLE;
					end else if (tx_acc) begin
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q  <= idx_q + AW'(1);
							load_q <= L_LOAD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rx_acc) begin
			type_q <= type_n;
		end
		if (load_q == L_LOAD) begin
			tx_byte_q <= rd_data;
			last_q    <= idx_last;
		end
	end

`ifndef NO_ASSERTIONS
	a_rx_tx_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_ready && tx_valid))
		else $error("rx open while forwarding");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(BUFFER_DEPTH))
		else $error("fill count beyond store depth");

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEND) |-> ((idx_q != '0) && (FW'(idx_q) < fill_q)))
		else $error("forward index outside frame");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(tx_acc && last_byte) |=> rx_ready)
		else $error("no return to reception after last byte");

	a_forward_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_acc && emit) |=> awaiting_q)
		else $error("forwarded frame without resync");
`endif

endmodule
